/* rtl/core/pdfm_pkg.sv */
package pdfm_pkg;

  localparam int unsigned StampWidth = 32;
  localparam int unsigned RateWidth  = 30;
  localparam int unsigned FreqWidth  = 37;
  localparam int unsigned DutyWidth  = 10;
  localparam int unsigned NumWidth   = 42;
  localparam int unsigned StepWidth  = 6;
  localparam int unsigned CfgIdxWidth = 1;

  localparam logic [StepWidth-1:0] FreqSteps = StepWidth'(FreqWidth);
  localparam logic [StepWidth-1:0] DutySteps = StepWidth'(NumWidth);

  localparam logic [DutyWidth-1:0] DutyCap       = 10'd1000;
  localparam logic [RateWidth-1:0] SlowRateReset = 30'd1000000;
  localparam logic [RateWidth-1:0] FastRateReset = 30'd150000000;

  localparam logic [CfgIdxWidth-1:0] CfgSlowRate = 1'b0;
  localparam logic [CfgIdxWidth-1:0] CfgFastRate = 1'b1;

  localparam int unsigned CmdRiseBit = 0;
  localparam int unsigned CmdFallBit = 1;

  localparam logic [1:0] JobFreqSlow = 2'd0;
  localparam logic [1:0] JobDutySlow = 2'd1;
  localparam logic [1:0] JobFreqFast = 2'd2;
  localparam logic [1:0] JobDutyFast = 2'd3;

  typedef struct packed {
    logic [1:0]            cmd;
    logic [StampWidth-1:0] stamp_slow;
    logic [StampWidth-1:0] stamp_fast;
  } pdfm_in_t;

  typedef struct packed {
    logic [StampWidth-1:0] period_slow;
    logic [StampWidth-1:0] high_slow;
    logic [FreqWidth-1:0]  freq_slow_centihz;
    logic [DutyWidth-1:0]  duty_slow_permille;
    logic [StampWidth-1:0] period_fast;
    logic [StampWidth-1:0] high_fast;
    logic [FreqWidth-1:0]  freq_fast_centihz;
    logic [DutyWidth-1:0]  duty_fast_permille;
  } pdfm_out_t;

endpackage

/* rtl/core/pdfm_div.sv */
module pdfm_div
  import pdfm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [NumWidth-1:0]   num_i,
  input  logic [StampWidth-1:0] den_i,
  input  logic [StepWidth-1:0]  steps_i,
  output logic                  busy_o,
  output logic                  done_o,
  output logic [NumWidth-1:0]   quot_o
);

  // Restoring division, one quotient bit per cycle. The numerator sits
  // left-aligned in n_q and quotient bits shift in at the bottom.
  logic [NumWidth-1:0]   n_q;
  logic [StampWidth-1:0] r_q;
  logic [StampWidth-1:0] den_q;
  logic [StepWidth-1:0]  cnt_q;
  logic                  busy_q;
  logic                  done_q;

  logic [StampWidth:0]   trial;
  logic [StampWidth+1:0] diff;
  logic                  ge;

  assign trial = {r_q, n_q[NumWidth-1]};
  assign diff  = {1'b0, trial} - {2'b00, den_q};
  assign ge    = ~diff[StampWidth+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == StepWidth'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      n_q   <= num_i;
      r_q   <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      n_q <= {n_q[NumWidth-2:0], ge};
      r_q <= ge ? diff[StampWidth-1:0] : trial[StampWidth-1:0];
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = n_q;

endmodule

/* rtl/core/period_duty_frequency_meter_unit.sv */
// Channel | Direction | Handshake                 | Word
// cfg     | in        | cfg_we_i                  | cfg_idx_i, cfg_data_i
// in      | in        | in_valid_i / in_stall_o   | in_word_i (pdfm_in_t)
// out     | out       | out_valid_o / out_stall_i | out_word_o (pdfm_out_t)
//
// A falling edge, an empty event or the first rising edge leaves the input
// unstalled. A measured rising edge starts four serial divisions of 37, 42,
// 37 and 42 steps on the one restoring divider, each launched and collected
// in turn, with entry and hand-off around them. The input is stalled meanwhile.
// The result waits in an output register, so new words are taken while it
// is stalled. Reset restores the rate registers and clears all edge history.
module period_duty_frequency_meter_unit
  import pdfm_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [RateWidth-1:0]   cfg_data_i,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  pdfm_in_t               in_word_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output pdfm_out_t              out_word_o
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StCalc = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  logic [1:0] state_q;
  logic [1:0] job_q;
  logic       launched_q;

  logic [RateWidth-1:0]  slow_rate_q, fast_rate_q;
  logic [StampWidth-1:0] rise_slow_q, rise_fast_q, fall_slow_q, fall_fast_q;
  logic                  rise_seen_q;

  logic [StampWidth-1:0] per_s_q, hi_s_q, per_f_q, hi_f_q;
  logic [FreqWidth-1:0]  fs_q, ff_q;
  logic [DutyWidth-1:0]  ds_q, df_q;

  pdfm_out_t out_q;
  logic      out_valid_q;

  logic in_acc, is_rise, is_fall, load_out;

  logic                  div_start, div_busy, div_done;
  logic [NumWidth-1:0]   div_num, div_quot;
  logic [StampWidth-1:0] per_sel, hi_sel;
  logic [RateWidth-1:0]  rate_sel;
  logic [FreqWidth-1:0]  rate_x100;
  logic [NumWidth-1:0]   hi_x1000, hi_ext;
  logic [FreqWidth-1:0]  rate_ext;
  logic [DutyWidth-1:0]  duty_capped;

  assign in_stall_o = (state_q != StIdle);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign is_rise    = in_word_i.cmd[CmdRiseBit];
  assign is_fall    = in_word_i.cmd[CmdFallBit];
  assign load_out   = (state_q == StDone) && (!out_valid_q || !out_stall_i);

  assign per_sel  = job_q[1] ? per_f_q : per_s_q;
  assign hi_sel   = job_q[1] ? hi_f_q : hi_s_q;
  assign rate_sel = job_q[1] ? fast_rate_q : slow_rate_q;

  assign rate_ext  = FreqWidth'(rate_sel);
  assign rate_x100 = (rate_ext << 6) + (rate_ext << 5) + (rate_ext << 2);
  assign hi_ext    = NumWidth'(hi_sel);
  assign hi_x1000  = (hi_ext << 10) - (hi_ext << 4) - (hi_ext << 3);

  assign div_num   = job_q[0] ? hi_x1000 : {rate_x100, {(NumWidth-FreqWidth){1'b0}}};
  assign div_start = (state_q == StCalc) && !launched_q && !div_busy && !div_done;

  assign duty_capped = (div_quot > NumWidth'(DutyCap)) ? DutyCap
                                                       : div_quot[DutyWidth-1:0];

  pdfm_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (per_sel),
    .steps_i (job_q[0] ? DutySteps : FreqSteps),
    .busy_o  (div_busy),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slow_rate_q <= SlowRateReset;
      fast_rate_q <= FastRateReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgSlowRate: slow_rate_q <= cfg_data_i;
        CfgFastRate: fast_rate_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rise_slow_q <= '0;
      rise_fast_q <= '0;
      fall_slow_q <= '0;
      fall_fast_q <= '0;
      rise_seen_q <= 1'b0;
    end else if (in_acc && is_rise) begin
      rise_slow_q <= in_word_i.stamp_slow;
      rise_fast_q <= in_word_i.stamp_fast;
      rise_seen_q <= 1'b1;
    end else if (in_acc && is_fall) begin
      fall_slow_q <= in_word_i.stamp_slow;
      fall_fast_q <= in_word_i.stamp_fast;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      job_q      <= JobFreqSlow;
      launched_q <= 1'b0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_acc && is_rise && rise_seen_q) begin
            state_q    <= StCalc;
            job_q      <= JobFreqSlow;
            launched_q <= 1'b0;
          end
        end
        StCalc: begin
          if (div_start) begin
            launched_q <= 1'b1;
          end else if (div_done) begin
            launched_q <= 1'b0;
            if (job_q == JobDutyFast) begin
              state_q <= StDone;
            end else begin
              job_q <= job_q + 1'b1;
            end
          end
        end
        StDone: begin
          if (load_out) begin
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && is_rise && rise_seen_q) begin
      per_s_q <= in_word_i.stamp_slow - rise_slow_q;
      hi_s_q  <= fall_slow_q - rise_slow_q;
      per_f_q <= in_word_i.stamp_fast - rise_fast_q;
      hi_f_q  <= fall_fast_q - rise_fast_q;
    end
    if ((state_q == StCalc) && div_done) begin
      case (job_q)
        JobFreqSlow: fs_q <= div_quot[FreqWidth-1:0];
        JobDutySlow: ds_q <= duty_capped;
        JobFreqFast: ff_q <= div_quot[FreqWidth-1:0];
        JobDutyFast: df_q <= duty_capped;
        default: ;
      endcase
    end
    if (load_out) begin
      out_q.period_slow        <= per_s_q;
      out_q.high_slow          <= hi_s_q;
      out_q.freq_slow_centihz  <= fs_q;
      out_q.duty_slow_permille <= ds_q;
      out_q.period_fast        <= per_f_q;
      out_q.high_fast          <= hi_f_q;
      out_q.freq_fast_centihz  <= ff_q;
      out_q.duty_fast_permille <= df_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

/* rtl/core/pdfm_checker.sv */
module pdfm_checker
  import pdfm_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_stall_o,
  input pdfm_in_t               in_word_i,
  input logic                   out_valid_o,
  input logic                   out_stall_i,
  input pdfm_out_t              out_word_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled result word was dropped");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_word_o))
    else $error("stalled result word changed");

  a_duty_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_word_o.duty_slow_permille <= DutyCap) &&
                    (out_word_o.duty_fast_permille <= DutyCap))
    else $error("duty above cap");

  a_zero_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.period_slow == '0) |->
      (out_word_o.freq_slow_centihz == '1) &&
      (out_word_o.duty_slow_permille == DutyCap))
    else $error("zero period did not saturate");

  a_no_rise_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !in_word_i.cmd[CmdRiseBit] |=> !in_stall_o)
    else $error("non-rising word stalled the input");

endmodule

bind period_duty_frequency_meter_unit pdfm_checker u_pdfm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_word_i   (in_word_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_word_o  (out_word_o)
);
